[rtl/sep3x3c_pkg.sv]
// ----------------------------------------------------------------------------
// sep3x3c_pkg
// Shared types, register codes and arithmetic helpers for the separable
// 3x3 convolution block.
// ----------------------------------------------------------------------------
package sep3x3c_pkg;

  // widths of the stream and register fields
  localparam int PIX_W      = 8;
  localparam int TAP_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  // wide enough for three tap products of a pixel
  localparam int SUM_W      = 19;

  localparam int PIX_MAX           = 255;
  localparam int DEFAULT_MAX_WIDTH = 1024;

  typedef logic        [PIX_W-1:0]      pix_t;
  typedef logic signed [TAP_W-1:0]      tap_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_FRAME_WIDTH    = 3'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT   = 3'd1;
  localparam cfg_idx_t REG_COL_TAP_ABOVE  = 3'd2;
  localparam cfg_idx_t REG_COL_TAP_MIDDLE = 3'd3;
  localparam cfg_idx_t REG_COL_TAP_BELOW  = 3'd4;
  localparam cfg_idx_t REG_ROW_TAP_LEFT   = 3'd5;
  localparam cfg_idx_t REG_ROW_TAP_MIDDLE = 3'd6;
  localparam cfg_idx_t REG_ROW_TAP_RIGHT  = 3'd7;

  // register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam tap_t            TAP_RST          = 8'sd1;

  // signed weight times unsigned pixel
  function automatic sum_t tap_mul(input tap_t tap, input pix_t pix);
    sum_t a;
    sum_t b;
    a = sum_t'(tap);
    b = {{(SUM_W-PIX_W){1'b0}}, pix};
    return a * b;
  endfunction

  // saturate a sum to the pixel range
  function automatic pix_t clamp_pix(input sum_t s);
    pix_t r;
    if (s >= sum_t'(PIX_MAX)) begin
      r = pix_t'(PIX_MAX);
    end else if (s <= sum_t'(0)) begin
      r = '0;
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/sep3x3c_in_if.sv]
// ----------------------------------------------------------------------------
// sep3x3c_in_if
// Pixel input channel: valid/ready handshake with pixel and fill flag.
// ----------------------------------------------------------------------------
interface sep3x3c_in_if;
  import sep3x3c_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_in;
  logic fill;

  modport source (output valid, pixel_in, fill, input ready);
  modport sink   (input valid, pixel_in, fill, output ready);
endinterface

[rtl/sep3x3c_out_if.sv]
// ----------------------------------------------------------------------------
// sep3x3c_out_if
// Filtered pixel channel: valid/ready handshake with pixel and frame end flag.
// ----------------------------------------------------------------------------
interface sep3x3c_out_if;
  import sep3x3c_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

[rtl/separable_3x3_convolution.sv]
// ----------------------------------------------------------------------------
// separable_3x3_convolution
// Streaming separable 3x3 filter over 8-bit grey frames in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one pixel per beat in raster order; after the last pixel of
//   a frame the producer sends frame_width+1 beats with fill set. out_bus gives
//   one filtered pixel per beat; the last one of a frame has frame_last set.
//   The result for pixel (x,y) comes out of the beat one line plus one pixel
//   later, so the first line and the first beat of the second line give no
//   result. cfg_we/cfg_idx/cfg_data write the frame size and the six tap
//   weights; write them only while the block is empty.
// Timing:
//   one beat per cycle sustained while out_bus.ready stays high. A beat
//   passes an input stage (line store read), a vertical multiply-add stage
//   and a horizontal multiply-add stage into the output register. The line
//   store takes one read and one write per cycle, which sets the
//   one-beat-per-cycle figure.
// Reset:
//   synchronous, active low; clears the pipeline, the frame position and
//   restores the register defaults. The line store is not cleared.
// Stall:
//   when out_bus.ready is low the result is held and the pipeline fills up;
//   in_bus.ready drops once all stages are occupied.
// ----------------------------------------------------------------------------
module separable_3x3_convolution #(
  parameter int MAX_WIDTH = sep3x3c_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sep3x3c_in_if.sink             in_bus,
  sep3x3c_out_if.source          out_bus,
  input  logic                   cfg_we,
  input  sep3x3c_pkg::cfg_idx_t  cfg_idx,
  input  sep3x3c_pkg::cfg_data_t cfg_data
);
  import sep3x3c_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int LW    = FH_W + 1;
  localparam int PRODW = WW + FH_W;
  localparam int CNTW  = WW + LW;

  typedef struct packed {
    logic l1;       // line above exists
    logic l2;       // two lines above exist
    logic c0;       // first column
    logic restart;  // frame ends after this beat
  } pos_flags_t;

  // configuration registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  tap_t col_above_r, col_middle_r, col_below_r;
  tap_t row_left_r, row_middle_r, row_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_above_r    <= TAP_RST;
      col_middle_r   <= TAP_RST;
      col_below_r    <= TAP_RST;
      row_left_r     <= TAP_RST;
      row_middle_r   <= TAP_RST;
      row_right_r    <= TAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:    frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_r <= cfg_data[FH_W-1:0];
        REG_COL_TAP_ABOVE:  col_above_r    <= cfg_data[TAP_W-1:0];
        REG_COL_TAP_MIDDLE: col_middle_r   <= cfg_data[TAP_W-1:0];
        REG_COL_TAP_BELOW:  col_below_r    <= cfg_data[TAP_W-1:0];
        REG_ROW_TAP_LEFT:   row_left_r     <= cfg_data[TAP_W-1:0];
        REG_ROW_TAP_MIDDLE: row_middle_r   <= cfg_data[TAP_W-1:0];
        REG_ROW_TAP_RIGHT:  row_right_r    <= cfg_data[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [LW-1:0]   h_plus1;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff   = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
    h_plus1 = {1'b0, h_eff} + LW'(1);
  end

  // handshake chain
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_go, s1_go, in_ready, accept;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s2_go    = s2_valid_r && out_free;
  assign s1_go    = s1_valid_r && (!s2_valid_r || s2_go);
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_bus.valid && in_ready;

  assign in_bus.ready = in_ready;

  // frame position of the incoming beat
  logic [CW-1:0] col_r, col_nxt;
  logic [LW-1:0] line_r, line_nxt;
  logic [WW-1:0] col_inc;
  logic          restart_c;
  pix_t          pix_c;

  always_comb begin
    restart_c = line_r >= h_plus1;
    col_inc   = {1'b0, col_r} + WW'(1);
    if (restart_c) begin
      col_nxt  = '0;
      line_nxt = '0;
    end else if (col_inc >= w_eff) begin
      col_nxt  = '0;
      line_nxt = line_r + LW'(1);
    end else begin
      col_nxt  = col_inc[CW-1:0];
      line_nxt = line_r;
    end
    pix_c = (in_bus.fill || line_r >= {1'b0, h_eff}) ? '0 : in_bus.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

  // input stage
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_col_r;
  pos_flags_t    s1_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r           <= pix_c;
      s1_col_r           <= col_r;
      s1_flags_r.l1      <= line_r >= LW'(1);
      s1_flags_r.l2      <= line_r >= LW'(2);
      s1_flags_r.c0      <= col_r == '0;
      s1_flags_r.restart <= restart_c;
    end
  end

  // line store: upper byte two lines back, lower byte one line back
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] store_rd_r;
  logic [2*PIX_W-1:0] store_wr;

  assign store_wr = {store_rd_r[PIX_W-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col_r] <= store_wr;
    end
  end

  // read at acceptance, bypass the write of the same column (one-pixel lines)
  always_ff @(posedge clk) begin
    if (accept) begin
      if (s1_go && s1_col_r == col_r) begin
        store_rd_r <= store_wr;
      end else begin
        store_rd_r <= line_mem[col_r];
      end
    end
  end

  // vertical pass
  pix_t             above_c;
  sum_t             vsum_c;
  pix_t             v_c;
  logic [PRODW-1:0] area_c;

  always_comb begin
    above_c = s1_flags_r.l2 ? store_rd_r[2*PIX_W-1:PIX_W] : '0;
    vsum_c  = tap_mul(col_above_r, above_c)
            + tap_mul(col_middle_r, store_rd_r[PIX_W-1:0])
            + tap_mul(col_below_r, s1_pix_r);
    v_c     = clamp_pix(vsum_c);
    area_c  = PRODW'(w_eff) * PRODW'(h_eff);
  end

  pix_t             s2_v_r;
  pos_flags_t       s2_flags_r;
  logic [PRODW-1:0] s2_last_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_v_r        <= v_c;
      s2_flags_r    <= s1_flags_r;
      s2_last_idx_r <= area_c - PRODW'(1);
    end
  end

  // horizontal pass over the last two vertical results and the new one, which is left out at a line start
  pix_t            vpipe0_r, vpipe1_r;
  logic [CNTW-1:0] cnt_r;
  sum_t            hsum_c;
  logic            emit_c, last_c;

  always_comb begin
    hsum_c = tap_mul(row_left_r, vpipe1_r) + tap_mul(row_middle_r, vpipe0_r);
    if (!s2_flags_r.c0) begin
      hsum_c = hsum_c + tap_mul(row_right_r, s2_v_r);
    end
    emit_c = s2_flags_r.c0 ? s2_flags_r.l2 : s2_flags_r.l1;
    last_c = CNTW'(s2_last_idx_r) == cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe0_r <= '0;
      vpipe1_r <= '0;
      cnt_r    <= '0;
    end else if (s2_go) begin
      if (s2_flags_r.restart) begin
        vpipe0_r <= '0;
        vpipe1_r <= '0;
        cnt_r    <= '0;
      end else begin
        if (emit_c) begin
          cnt_r <= cnt_r + CNTW'(1);
        end
        if (s2_flags_r.l1) begin
          vpipe1_r <= s2_flags_r.c0 ? '0 : vpipe0_r;
          vpipe0_r <= s2_v_r;
        end
      end
    end
  end

  // output register
  pix_t out_pix_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && emit_c) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && emit_c) begin
      out_pix_r  <= clamp_pix(hsum_c);
      out_last_r <= last_c;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.pixel_out  = out_pix_r;
  assign out_bus.frame_last = out_last_r;

  // checks
  a_restart_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    accept && restart_c |=> col_r == '0 && line_r == '0)
    else $error("frame position not cleared at frame end");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |=> {1'b0, col_r} < w_eff)
    else $error("column position beyond line width");

  a_restart_clears_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go && s2_flags_r.restart |=> vpipe0_r == '0 && vpipe1_r == '0 && cnt_r == '0)
    else $error("horizontal state not cleared at frame end");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go && emit_c |=> out_valid_r)
    else $error("result beat lost");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r && !s2_go |-> !in_bus.ready)
    else $error("input taken while pipeline is stalled");

endmodule

[dv/separable_3x3_convolution_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// separable_3x3_convolution_test
// Self-checking bench for the separable 3x3 filter. Whole frames with their
// trailing fill beats stream in under random bursts and output stalls. A
// cycle-free software copy of the filter predicts every output pixel, and
// each output beat is checked against it. The frame size and the six taps
// are rewritten between phases, and the extremes are covered.
// ----------------------------------------------------------------------------
module separable_3x3_convolution_test;
  import sep3x3c_pkg::*;

  localparam int MAX_LINE       = 1024;
  localparam int RANDOM_BEATS   = 1200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SQUEEZE_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    pix_t pixel;
    logic fill;
  } pixel_beat_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_end;
  } filtered_px_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;

  sep3x3c_in_if  in_bus ();
  sep3x3c_out_if out_bus ();

  separable_3x3_convolution #(.MAX_WIDTH(MAX_LINE)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // register copies used by the filter model
  int frame_w_reg = int'(FRAME_WIDTH_RST);
  int frame_h_reg = int'(FRAME_HEIGHT_RST);
  int v_tap [3]   = '{1, 1, 1};
  int h_tap [3]   = '{1, 1, 1};

  // filter model state
  pix_t older_line [MAX_LINE];
  pix_t newer_line [MAX_LINE];
  int   vert_hist [2] = '{0, 0};
  int   col_cnt = 0;
  int   row_cnt = 0;
  int   out_cnt = 0;

  pixel_beat_t  pixel_backlog [$];
  filtered_px_t expected_pixels [$];

  int mismatches      = 0;
  int results_checked = 0;
  int beats_accepted  = 0;
  int beats_queued    = 0;
  int frames_sent     = 0;
  int settings_used   = 0;
  int idle_cycles     = 0;

  logic     in_taken     = 1'b0;
  int       burst_left   = 1;
  int       gap_left     = 0;
  logic     squeeze_req  = 1'b0;
  logic     squeeze_done = 1'b0;
  int       hold_left    = 0;
  int       mode_left    = 0;
  rx_mode_t stall_mode   = RX_OPEN;

  always #10 clk = ~clk;

  function automatic int eff_width();
    int w;
    w = frame_w_reg;
    if (w == 0) w = 1;
    if (w > MAX_LINE) w = MAX_LINE;
    return w;
  endfunction

  function automatic int eff_height();
    return (frame_h_reg == 0) ? 1 : frame_h_reg;
  endfunction

  function automatic int clip_pixel(input int s);
    if (s >= 255) return 255;
    if (s <= 0) return 0;
    return s;
  endfunction

  // one input beat through the filter; queues the output pixel it releases
  function automatic void filter_pixel(input pix_t pix, input logic fill_flag);
    int w, h, c, l, ci, p, above, middle, v;
    filtered_px_t r;
    logic emit;
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    l = row_cnt;
    ci = c % MAX_LINE;
    v = 0;
    emit = 1'b0;
    r.pixel = '0;
    r.frame_end = 1'b0;
    // fill beats and anything past the last line count as black
    p = (fill_flag || l >= h) ? 0 : int'(pix);

    // vertical pass for the line above the current one
    if (l >= 1) begin
      above = (l >= 2) ? int'(older_line[ci]) : 0;
      middle = int'(newer_line[ci]);
      v = clip_pixel(v_tap[0] * above + v_tap[1] * middle + v_tap[2] * p);
    end
    older_line[ci] = newer_line[ci];
    newer_line[ci] = pix_t'(p);

    // horizontal pass, the right neighbor is zero at a line start
    if (c == 0) begin
      if (l >= 2) begin
        r.pixel = pix_t'(clip_pixel(h_tap[0] * vert_hist[1] + h_tap[1] * vert_hist[0]));
        emit = 1'b1;
      end
      if (l >= 1) begin
        vert_hist[1] = 0;
        vert_hist[0] = v;
      end
    end else if (l >= 1) begin
      r.pixel = pix_t'(clip_pixel(h_tap[0] * vert_hist[1] + h_tap[1] * vert_hist[0]
                                  + h_tap[2] * v));
      emit = 1'b1;
      vert_hist[1] = vert_hist[0];
      vert_hist[0] = v;
    end

    if (emit) begin
      r.frame_end = (out_cnt == w * h - 1);
      expected_pixels.push_back(r);
      out_cnt++;
    end

    // raster position, frame wraps after the trailing fill
    c++;
    if (c >= w) begin
      c = 0;
      l++;
    end
    col_cnt = c;
    row_cnt = l;
    if (l > h + 1 || (l == h + 1 && c > 0) || (l - ((c == 0) ? 1 : 0)) >= h + 1) begin
      vert_hist[0] = 0;
      vert_hist[1] = 0;
      col_cnt = 0;
      row_cnt = 0;
      out_cnt = 0;
    end
  endfunction

  function automatic int pick_tap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 2))
        0: return -128;
        1: return 127;
        default: return 0;
      endcase
    end
    if (r < 6) return int'($urandom_range(0, 6)) - 3;
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  function automatic void add_beat(input pix_t pix, input logic fill_flag);
    pixel_beat_t b;
    b.pixel = pix;
    b.fill = fill_flag;
    pixel_backlog.push_back(b);
    beats_queued++;
  endfunction

  // one full frame at the current size plus width+1 trailing beats
  task automatic queue_frame();
    int w, h, n;
    w = eff_width();
    h = eff_height();
    for (n = 0; n < w * h; n++) begin
      add_beat(pix_t'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
    end
    // mostly fill beats, now and then a stray real pixel past the frame
    for (n = 0; n <= w; n++) begin
      add_beat(pix_t'($urandom_range(0, 255)), $urandom_range(0, 5) != 0);
    end
    frames_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= cfg_data_t'(value);
    case (idx)
      REG_FRAME_WIDTH:    frame_w_reg = value & 'h7FF;
      REG_FRAME_HEIGHT:   frame_h_reg = value & 'h1FFF;
      REG_COL_TAP_ABOVE:  v_tap[0] = int'(tap_t'(value));
      REG_COL_TAP_MIDDLE: v_tap[1] = int'(tap_t'(value));
      REG_COL_TAP_BELOW:  v_tap[2] = int'(tap_t'(value));
      REG_ROW_TAP_LEFT:   h_tap[0] = int'(tap_t'(value));
      REG_ROW_TAP_MIDDLE: h_tap[1] = int'(tap_t'(value));
      REG_ROW_TAP_RIGHT:  h_tap[2] = int'(tap_t'(value));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int w, input int h, input int ca, input int cm,
                               input int cb, input int rl, input int rm, input int rr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_COL_TAP_ABOVE, ca);
    write_reg(REG_COL_TAP_MIDDLE, cm);
    write_reg(REG_COL_TAP_BELOW, cb);
    write_reg(REG_ROW_TAP_LEFT, rl);
    write_reg(REG_ROW_TAP_MIDDLE, rm);
    write_reg(REG_ROW_TAP_RIGHT, rr);
    settings_used++;
  endtask

  // wait until every queued beat is in and every expected pixel is out
  task automatic settle();
    while (pixel_backlog.size() != 0 || in_bus.valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin : feed_pixels
    logic offer;
    offer = 1'b0;
    if (rst_n) begin
      if (in_bus.valid && in_taken) begin
        void'(pixel_backlog.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (in_bus.valid && !in_taken) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else begin
        offer = (pixel_backlog.size() != 0);
      end
    end
    in_bus.valid <= offer;
    if (offer) begin
      in_bus.pixel_in <= pixel_backlog[0].pixel;
      in_bus.fill     <= pixel_backlog[0].fill;
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  always @(negedge clk) begin : drain_pixels
    logic rdy;
    rdy = 1'b0;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      hold_left    <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_HALF:   rdy = $urandom_range(0, 1) == 1;
        RX_SPARSE: rdy = $urandom_range(0, 3) == 0;
        default:   rdy = $urandom_range(0, 9) != 0;
      endcase
    end
    out_bus.ready <= rdy;
  end

  // beats on both channels, checked against the model
  always @(posedge clk) begin : watch_ports
    filtered_px_t want;
    in_taken <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        filter_pixel(in_bus.pixel_in, in_bus.fill);
        beats_accepted++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output beat pixel_out=%0d frame_last=%0b",
                   $time, out_bus.pixel_out, out_bus.frame_last);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (out_bus.pixel_out !== want.pixel) begin
            $display("%0t: pixel_out expected %0d actual %0d",
                     $time, want.pixel, out_bus.pixel_out);
            mismatches++;
          end
          if (out_bus.frame_last !== want.frame_end) begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, want.frame_end, out_bus.frame_last);
            mismatches++;
          end
        end
      end
    end
  end

  // no beat on either side for too long ends the run
  always @(posedge clk) begin : watchdog
    if (rst_n && ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d pixels still expected",
               $time, idle_cycles, expected_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int mark, w, h, phase_no, n, nf;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_FRAME_WIDTH;
    cfg_data        = '0;
    foreach (older_line[i]) older_line[i] = '0;
    foreach (newer_line[i]) newer_line[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3 frame: black and white pixels, a fill inside the frame,
    // a real pixel after the last line
    apply_setting(3, 3, -1, 2, 1, 1, 2, -1);
    add_beat(8'd255, 1'b0); add_beat(8'd0, 1'b0);   add_beat(8'd255, 1'b0);
    add_beat(8'd255, 1'b1); add_beat(8'd128, 1'b0); add_beat(8'd1, 1'b0);
    add_beat(8'd255, 1'b0); add_beat(8'd255, 1'b0); add_beat(8'd255, 1'b0);
    add_beat(8'd0, 1'b1);   add_beat(8'd200, 1'b0); add_beat(8'd255, 1'b1);
    add_beat(8'd0, 1'b1);
    frames_sent++;
    settle();

    // zero width and zero height both act as one, taps at their limits
    apply_setting(0, 0, 127, -128, 127, -128, 127, 127);
    add_beat(8'd255, 1'b0); add_beat(8'd255, 1'b0); add_beat(8'd0, 1'b1);
    frames_sent++;
    settle();

    // random phases, mostly small frames
    mark = beats_queued;
    phase_no = 0;
    while (beats_queued - mark < RANDOM_BEATS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 8);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
      case (phase_no)
        0: apply_setting(w, h, 127, 127, 127, 127, 127, 127);
        1: apply_setting(w, h, -128, -128, -128, -128, -128, -128);
        2: apply_setting(w, h, 0, 0, 0, 0, 0, 0);
        default: apply_setting(w, h, pick_tap(), pick_tap(), pick_tap(),
                               pick_tap(), pick_tap(), pick_tap());
      endcase
      nf = $urandom_range(1, 4);
      for (n = 0; n < nf && beats_queued - mark < RANDOM_BEATS; n++) begin
        queue_frame();
      end
      settle();
      phase_no++;
    end

    // wider line, with a long output hold-off that backs up the input
    apply_setting(40, 3, 1, 2, 1, -1, 3, -1);
    squeeze_req = 1'b1;
    queue_frame();
    settle();

    // tall frame at one pixel per line
    apply_setting(1, 150, 0, 1, 2, 1, 1, 0);
    queue_frame();
    settle();

    $display("frames: %0d over %0d register settings, %0d input beats accepted",
             frames_sent, settings_used, beats_accepted);
    $display("filtered pixels checked: %0d, mismatches: %0d", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
